/* rtl/tbn_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the triangle bounds and unit normal pipeline.
// No dependencies; every other file imports this package.
package tbn_pkg;

    localparam int FIELD_BITS     = 32;
    localparam int COORD_BITS_DEF = 32;
    localparam int UNIT_FRAC      = 30;
    localparam int UNIT_ONE       = 1 << UNIT_FRAC;
    // The root search produces twice the Q2.30 magnitude, so it needs two extra bits.
    localparam int ROOT_BITS      = UNIT_FRAC + 2;
    localparam int ROOT_SHIFT     = 2 * (UNIT_FRAC + 1);
    localparam int MUL_SLICE      = 17;

    typedef struct packed {
        logic [2:0][FIELD_BITS-1:0] lo;
        logic [2:0][FIELD_BITS-1:0] hi;
    } t_box;

    typedef struct packed {
        t_box                       box;
        logic [2:0][FIELD_BITS-1:0] nrm;
        logic                       deg;
    } t_res;

endpackage

/* rtl/tbn_in_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one triangle (three vertices) with valid/ready.
// Depends on tbn_pkg.
interface tbn_in_if import tbn_pkg::*; #(parameter int W = FIELD_BITS) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] v0_x, v0_y, v0_z;
    logic signed [W-1:0] v1_x, v1_y, v1_z;
    logic signed [W-1:0] v2_x, v2_y, v2_z;

    modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, input ready);
    modport sink   (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
                    v2_x, v2_y, v2_z, output ready);
endinterface

/* rtl/tbn_out_if.sv */
`timescale 1ns / 1ps
// Output channel carrying bounding box, unit normal and degenerate flag.
// Depends on tbn_pkg.
interface tbn_out_if import tbn_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [FIELD_BITS-1:0] box_min_x, box_min_y, box_min_z;
    logic signed [FIELD_BITS-1:0] box_max_x, box_max_y, box_max_z;
    logic signed [FIELD_BITS-1:0] normal_x, normal_y, normal_z;
    logic                         degenerate;

    modport source (output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                    box_max_z, normal_x, normal_y, normal_z, degenerate, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y,
                    box_max_z, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

/* rtl/tbn_front.sv */
`timescale 1ns / 1ps
// First pipeline stage: per-axis min/max box and edge vectors in sign-magnitude form.
// Depends on tbn_pkg.
module tbn_front import tbn_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [2:0][2:0][COORD_BITS-1:0]   i_vtx,
    output t_box                              o_box,
    output logic [2:0][COORD_BITS:0]          o_e1_mag,
    output logic [2:0][COORD_BITS:0]          o_e2_mag,
    output logic [2:0]                        o_e1_neg,
    output logic [2:0]                        o_e2_neg
);

    localparam int EW = COORD_BITS + 1;
    localparam int MX = (COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS;

    t_box                  r_box, n_box;
    logic [2:0][EW-1:0]    r_e1_mag, n_e1_mag, r_e2_mag, n_e2_mag;
    logic [2:0]            r_e1_neg, n_e1_neg, r_e2_neg, n_e2_neg;

    always_comb begin
        logic signed [COORD_BITS-1:0] c0, c1, c2, lo, hi;
        logic signed [EW-1:0]         d1, d2;
        logic signed [MX-1:0]         xlo, xhi;
        for (int a = 0; a < 3; a++) begin
            c0 = $signed(i_vtx[0][a]);
            c1 = $signed(i_vtx[1][a]);
            c2 = $signed(i_vtx[2][a]);
            lo = c0;
            hi = c0;
            if (c1 < lo) lo = c1;
            if (c2 < lo) lo = c2;
            if (c1 > hi) hi = c1;
            if (c2 > hi) hi = c2;
            xlo = MX'(lo);
            xhi = MX'(hi);
            n_box.lo[a] = xlo[FIELD_BITS-1:0];
            n_box.hi[a] = xhi[FIELD_BITS-1:0];
            d1 = EW'(c1) - EW'(c0);
            d2 = EW'(c2) - EW'(c0);
            n_e1_neg[a] = d1[EW-1];
            n_e2_neg[a] = d2[EW-1];
            n_e1_mag[a] = d1[EW-1] ? EW'(-d1) : EW'(d1);
            n_e2_mag[a] = d2[EW-1] ? EW'(-d2) : EW'(d2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_box    <= n_box;
            r_e1_mag <= n_e1_mag;
            r_e2_mag <= n_e2_mag;
            r_e1_neg <= n_e1_neg;
            r_e2_neg <= n_e2_neg;
        end
    end

    assign o_box    = r_box;
    assign o_e1_mag = r_e1_mag;
    assign o_e2_mag = r_e2_mag;
    assign o_e1_neg = r_e1_neg;
    assign o_e2_neg = r_e2_neg;

endmodule

/* rtl/tbn_mul.sv */
`timescale 1ns / 1ps
// Pipelined unsigned multiplier, several lanes, one operand slice per stage.
// Depends on tbn_pkg for the slice width.
module tbn_mul import tbn_pkg::*; #(
    parameter int LANES  = 1,
    parameter int AW     = 16,
    parameter int BW     = 16,
    parameter int SIDE_W = 1
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [LANES-1:0][AW-1:0]       i_a,
    input  logic [LANES-1:0][BW-1:0]       i_b,
    input  logic [SIDE_W-1:0]              i_side,
    output logic [LANES-1:0][AW+BW-1:0]    o_p,
    output logic [SIDE_W-1:0]              o_side
);

    localparam int KW  = MUL_SLICE;
    localparam int NST = (BW + KW - 1) / KW;
    localparam int BPW = NST * KW;
    localparam int PW  = AW + BW;
    localparam int XW  = AW + KW;
    localparam int AST = (NST > 1) ? NST - 1 : 1;

    logic [LANES-1:0][BPW-1:0] b_pad;
    logic [LANES-1:0][AW-1:0]  q_a    [AST];
    logic [LANES-1:0][BPW-1:0] q_b    [AST];
    logic [LANES-1:0][PW-1:0]  q_acc  [NST];
    logic [SIDE_W-1:0]         q_side [NST];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            b_pad[l] = BPW'(i_b[l]);
        end
    end

    for (genvar j = 0; j < NST; j++) begin : g_st
        logic [LANES-1:0][AW-1:0]  a_in;
        logic [LANES-1:0][BPW-1:0] b_in;
        logic [LANES-1:0][PW-1:0]  acc_in, n_acc, r_acc;
        logic [SIDE_W-1:0]         side_in, r_side;

        if (j == 0) begin : g_first
            assign a_in    = i_a;
            assign b_in    = b_pad;
            assign acc_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign a_in    = q_a[j-1];
            assign b_in    = q_b[j-1];
            assign acc_in  = q_acc[j-1];
            assign side_in = q_side[j-1];
        end

        always_comb begin
            logic [XW-1:0] prod;
            for (int l = 0; l < LANES; l++) begin
                prod     = XW'(a_in[l]) * XW'(b_in[l][j*KW +: KW]);
                n_acc[l] = acc_in[l] + (PW'(prod) << (j * KW));
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc  <= n_acc;
                r_side <= side_in;
            end
        end
        assign q_acc[j]  = r_acc;
        assign q_side[j] = r_side;

        if (j < NST - 1) begin : g_fwd
            logic [LANES-1:0][AW-1:0]  r_a;
            logic [LANES-1:0][BPW-1:0] r_b;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= a_in;
                    r_b <= b_in;
                end
            end
            assign q_a[j] = r_a;
            assign q_b[j] = r_b;
        end
    end

    assign o_p    = q_acc[NST-1];
    assign o_side = q_side[NST-1];

endmodule

/* rtl/tbn_root.sv */
`timescale 1ns / 1ps
// Digit-recurrence stages: per lane the largest y with y*y*s <= n2 * 2^ROOT_SHIFT,
// one result bit per stage, three lanes sharing one s. Depends on tbn_pkg.
module tbn_root import tbn_pkg::*; #(
    parameter int SW     = 16,
    parameter int N2W    = 14,
    parameter int SIDE_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [SW-1:0]                 i_s,
    input  logic [2:0][N2W-1:0]           i_n2,
    input  logic [SIDE_W-1:0]             i_side,
    output logic [2:0][ROOT_BITS-1:0]     o_y,
    output logic [SIDE_W-1:0]             o_side
);

    localparam int YB  = ROOT_BITS;
    localparam int RW  = SW + 2 * YB + 1;
    localparam int YSW = SW + YB;

    logic [2:0][RW-1:0]  q_rem  [YB-1];
    logic [2:0][YSW-1:0] q_ys   [YB-1];
    logic [SW-1:0]       q_s    [YB-1];
    logic [2:0][YB-1:0]  q_y    [YB];
    logic [SIDE_W-1:0]   q_side [YB];

    for (genvar k = 0; k < YB; k++) begin : g_st
        localparam int B = YB - 1 - k;
        logic [2:0][RW-1:0]  rem_in, n_rem;
        logic [2:0][YSW-1:0] ys_in, n_ys;
        logic [2:0][YB-1:0]  y_in, n_y, r_y;
        logic [SW-1:0]       s_in;
        logic [SIDE_W-1:0]   side_in, r_side;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < 3; l++) begin
                    rem_in[l] = RW'(i_n2[l]) << ROOT_SHIFT;
                end
            end
            assign ys_in   = '0;
            assign y_in    = '0;
            assign s_in    = i_s;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = q_rem[k-1];
            assign ys_in   = q_ys[k-1];
            assign y_in    = q_y[k-1];
            assign s_in    = q_s[k-1];
            assign side_in = q_side[k-1];
        end

        // Setting bit B adds (2^(B+1) * y + 2^(2B)) * s to y*y*s.
        always_comb begin
            logic [RW-1:0] d;
            logic          take;
            n_y = y_in;
            for (int l = 0; l < 3; l++) begin
                d        = (RW'(ys_in[l]) << (B + 1)) + (RW'(s_in) << (2 * B));
                take     = (rem_in[l] >= d);
                n_rem[l] = take ? rem_in[l] - d : rem_in[l];
                n_ys[l]  = take ? ys_in[l] + (YSW'(s_in) << B) : ys_in[l];
                n_y[l][B] = take;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_y    <= n_y;
                r_side <= side_in;
            end
        end
        assign q_y[k]    = r_y;
        assign q_side[k] = r_side;

        if (k < YB - 1) begin : g_fwd
            logic [2:0][RW-1:0]  r_rem;
            logic [2:0][YSW-1:0] r_ys;
            logic [SW-1:0]       r_s;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem <= n_rem;
                    r_ys  <= n_ys;
                    r_s   <= s_in;
                end
            end
            assign q_rem[k] = r_rem;
            assign q_ys[k]  = r_ys;
            assign q_s[k]   = r_s;
        end
    end

    assign o_y    = q_y[YB-1];
    assign o_side = q_side[YB-1];

endmodule

/* rtl/triangle_bounds_and_unit_normal.sv */
`timescale 1ns / 1ps
// Path: front stage, edge-product multiplier, cross-component register, square multiplier,
// squared-length register and root stages, from input transfer to the output register.
// Throughput: one triangle per cycle; every stage advances together while the output skid
// register is empty, so a stalled result holds the pipeline after one more transfer.
// Reset clears the stage valid bits and the output/skid valid flags; data registers keep
// whatever they hold.
module triangle_bounds_and_unit_normal import tbn_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbn_in_if.sink    i_tri,
    tbn_out_if.source o_res
);

    // Widths along the datapath.
    localparam int C     = COORD_BITS;
    localparam int VW    = (C > FIELD_BITS) ? C : FIELD_BITS;  // coordinate field, zero-extended
    localparam int EW    = C + 1;            // edge magnitude
    localparam int PW1   = 2 * EW;           // edge product magnitude
    localparam int DW    = PW1 + 2;          // signed cross component before abs
    localparam int MW    = 2 * C + 2;        // cross component magnitude
    localparam int SQW   = 2 * MW;           // squared component
    localparam int SW    = SQW + 2;          // sum of three squares
    localparam int YB    = ROOT_BITS;
    localparam int MS1   = (EW + MUL_SLICE - 1) / MUL_SLICE;
    localparam int MS2   = (MW + MUL_SLICE - 1) / MUL_SLICE;
    localparam int NS    = 3 + MS1 + MS2 + YB;
    localparam int SIDE1 = $bits(t_box) + 6;
    localparam int SIDE2 = $bits(t_box) + 4;

    // Global advance: all stages move when the skid register is free.
    logic          en;
    logic [NS-1:0] r_vld;
    t_res          r_out, r_skid, res;
    logic          r_out_vld, r_skid_vld;
    logic          push, pop;

    assign en          = ~r_skid_vld;
    assign i_tri.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_tri.valid};
        end
    end

    // Stage 0: box and edges. A coordinate is the low COORD_BITS bits of its field; a
    // coordinate wider than the field sees the field zero-extended.
    logic [2:0][2:0][C-1:0] vtx;
    t_box                   f_box;
    logic [2:0][EW-1:0]     f_e1_mag, f_e2_mag;
    logic [2:0]             f_e1_neg, f_e2_neg;

    assign vtx[0][0] = C'(VW'($unsigned(i_tri.v0_x)));
    assign vtx[0][1] = C'(VW'($unsigned(i_tri.v0_y)));
    assign vtx[0][2] = C'(VW'($unsigned(i_tri.v0_z)));
    assign vtx[1][0] = C'(VW'($unsigned(i_tri.v1_x)));
    assign vtx[1][1] = C'(VW'($unsigned(i_tri.v1_y)));
    assign vtx[1][2] = C'(VW'($unsigned(i_tri.v1_z)));
    assign vtx[2][0] = C'(VW'($unsigned(i_tri.v2_x)));
    assign vtx[2][1] = C'(VW'($unsigned(i_tri.v2_y)));
    assign vtx[2][2] = C'(VW'($unsigned(i_tri.v2_z)));

    tbn_front #(.COORD_BITS(C)) u_front (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_vtx    (vtx),
        .o_box    (f_box),
        .o_e1_mag (f_e1_mag),
        .o_e2_mag (f_e2_mag),
        .o_e1_neg (f_e1_neg),
        .o_e2_neg (f_e2_neg)
    );

    // Six products of edge components for the cross product. Lanes come in pairs per axis:
    // the even lane is the positive term and the odd lane the one subtracted.
    logic [5:0][EW-1:0]  m1_a, m1_b;
    logic [5:0]          m1_neg, m1_sgn;
    logic [5:0][PW1-1:0] m1_p;
    logic [SIDE1-1:0]    m1_side;
    t_box                m1_box;

    assign m1_a = {f_e1_mag[1], f_e1_mag[0], f_e1_mag[0], f_e1_mag[2], f_e1_mag[2], f_e1_mag[1]};
    assign m1_b = {f_e2_mag[0], f_e2_mag[1], f_e2_mag[2], f_e2_mag[0], f_e2_mag[1], f_e2_mag[2]};
    assign m1_neg = {f_e1_neg[1] ^ f_e2_neg[0], f_e1_neg[0] ^ f_e2_neg[1],
                     f_e1_neg[0] ^ f_e2_neg[2], f_e1_neg[2] ^ f_e2_neg[0],
                     f_e1_neg[2] ^ f_e2_neg[1], f_e1_neg[1] ^ f_e2_neg[2]};

    tbn_mul #(.LANES(6), .AW(EW), .BW(EW), .SIDE_W(SIDE1)) u_mul_edge (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (m1_a),
        .i_b    (m1_b),
        .i_side ({f_box, m1_neg}),
        .o_p    (m1_p),
        .o_side (m1_side)
    );
    assign {m1_box, m1_sgn} = m1_side;

    // Cross components in sign-magnitude; a zero vector marks a degenerate triangle.
    logic [2:0][MW-1:0] r_nmag, n_nmag;
    logic [2:0]         r_nneg, n_nneg;
    logic               r_ndeg, n_ndeg;
    t_box               r_box1;

    always_comb begin
        logic [DW-1:0] sp0, sp1, dn;
        for (int c = 0; c < 3; c++) begin
            sp0       = m1_sgn[2*c]   ? -DW'(m1_p[2*c])   : DW'(m1_p[2*c]);
            sp1       = m1_sgn[2*c+1] ? -DW'(m1_p[2*c+1]) : DW'(m1_p[2*c+1]);
            dn        = sp0 - sp1;
            n_nneg[c] = dn[DW-1];
            n_nmag[c] = MW'(dn[DW-1] ? -dn : dn);
        end
        n_ndeg = (n_nmag[0] == '0) && (n_nmag[1] == '0) && (n_nmag[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nmag <= n_nmag;
            r_nneg <= n_nneg;
            r_ndeg <= n_ndeg;
            r_box1 <= m1_box;
        end
    end

    // Squares of the component magnitudes.
    logic [2:0][SQW-1:0] m2_p;
    logic [SIDE2-1:0]    m2_side;

    tbn_mul #(.LANES(3), .AW(MW), .BW(MW), .SIDE_W(SIDE2)) u_mul_sq (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_nmag),
        .i_b    (r_nmag),
        .i_side ({r_box1, r_nneg, r_ndeg}),
        .o_p    (m2_p),
        .o_side (m2_side)
    );

    // Squared length.
    logic [SW-1:0]       r_s;
    logic [2:0][SQW-1:0] r_n2;
    logic [SIDE2-1:0]    r_side2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s     <= SW'(m2_p[0]) + SW'(m2_p[1]) + SW'(m2_p[2]);
            r_n2    <= m2_p;
            r_side2 <= m2_side;
        end
    end

    // Square-root divide: y = floor(|n| * 2^31 / length), exact.
    logic [2:0][YB-1:0] rt_y;
    logic [SIDE2-1:0]   rt_side;
    t_box               rt_box;
    logic [2:0]         rt_neg;
    logic               rt_deg;

    tbn_root #(.SW(SW), .N2W(SQW), .SIDE_W(SIDE2)) u_root (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (r_s),
        .i_n2   (r_n2),
        .i_side (r_side2),
        .o_y    (rt_y),
        .o_side (rt_side)
    );
    assign {rt_box, rt_neg, rt_deg} = rt_side;

    // Halving y with a carry-in gives the Q2.30 value rounded half away from zero.
    always_comb begin
        logic [YB:0]           qs;
        logic [FIELD_BITS-1:0] q;
        res.box = rt_box;
        res.deg = rt_deg;
        for (int c = 0; c < 3; c++) begin
            qs = (YB + 1)'(rt_y[c]) + (YB + 1)'(1);
            q  = FIELD_BITS'(qs[YB:1]);
            if (rt_deg) begin
                res.nrm[c] = '0;
            end else begin
                res.nrm[c] = rt_neg[c] ? -q : q;
            end
        end
    end

    // Output register with a skid entry behind it, so the pipeline sees a registered ready.
    assign push = en & r_vld[NS-1];
    assign pop  = r_out_vld & o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (push) begin
            if (!r_out_vld || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.box_min_x  = r_out.box.lo[0];
    assign o_res.box_min_y  = r_out.box.lo[1];
    assign o_res.box_min_z  = r_out.box.lo[2];
    assign o_res.box_max_x  = r_out.box.hi[0];
    assign o_res.box_max_y  = r_out.box.hi[1];
    assign o_res.box_max_z  = r_out.box.hi[2];
    assign o_res.normal_x   = r_out.nrm[0];
    assign o_res.normal_y   = r_out.nrm[1];
    assign o_res.normal_z   = r_out.nrm[2];
    assign o_res.degenerate = r_out.deg;

    // The skid entry only fills behind a waiting output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid while output register empty");

    // A stall freezes every stage valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    // A degenerate result carries a zero normal.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.deg) |-> (r_out.nrm == '0))
        else $error("degenerate result with a nonzero normal");

    // Each unit normal component stays within plus or minus one in Q2.30.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($signed(r_out.nrm[0]) <= UNIT_ONE && $signed(r_out.nrm[0]) >= -UNIT_ONE
                    && $signed(r_out.nrm[1]) <= UNIT_ONE && $signed(r_out.nrm[1]) >= -UNIT_ONE
                    && $signed(r_out.nrm[2]) <= UNIT_ONE && $signed(r_out.nrm[2]) >= -UNIT_ONE))
        else $error("normal component out of unit range");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for triangle_bounds_and_unit_normal: directed triangles, then random
// ones, with the box and unit normal predicted in wide integer arithmetic.
// Depends on tbn_pkg, tbn_in_if, tbn_out_if and the block itself.
module testbench;
    import tbn_pkg::*;

    localparam int  N_RANDOM    = 1930;
    localparam int  MAX_IDLE    = 4000;
    localparam int  DRAIN_WAIT  = 80;
    localparam int  LONG_HOLD   = 300;
    localparam int  ONE_Q16     = 1 << 16;

    typedef struct {
        int v[3][3];
    } t_tri;

    typedef struct {
        int   lo[3];
        int   hi[3];
        int   nrm[3];
        logic deg;
    } t_bounds;

    // One directed row: a triangle and, where it is obvious, the expected answer.
    typedef struct {
        t_tri    shape;
        bit      typed;
        t_bounds want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tbn_in_if  tri_ch ();
    tbn_out_if res_ch ();

    triangle_bounds_and_unit_normal dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tri   (tri_ch.sink),
        .o_res   (res_ch.source)
    );

    // Results still owed by the block, oldest first.
    t_bounds pending_results[$];
    int      n_mismatch;
    int      n_checked;
    int      n_degenerate;
    int      n_sent;
    bit      sending_done;
    bit      hold_done;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // ------------------------------------------------------------------
    // Predictor. The unit normal component is the largest q in 0..2^30 with
    // s * (2q - 1)^2 <= n^2 * 2^62, which is |n| * 2^30 / sqrt(s) rounded to
    // nearest with ties away from zero. The squares and their products are held
    // in 256-bit integers so no step can overflow.
    // ------------------------------------------------------------------
    function automatic longint unit_component(logic [255:0] mag, logic [255:0] sumsq);
        longint       lo;
        longint       hi;
        longint       mid;
        longint       odd;
        logic [255:0] odd_sq;
        logic [255:0] rhs;
        lo  = 0;
        hi  = longint'(UNIT_ONE);
        rhs = (mag * mag) << 62;
        while (lo < hi) begin
            mid    = (lo + hi + 1) >>> 1;
            odd    = 2 * mid - 1;
            odd_sq = 256'(odd * odd);
            if (sumsq * odd_sq <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    function automatic t_bounds predict_bounds(t_tri t);
        t_bounds             r;
        longint              e1[3];
        longint              e2[3];
        logic signed [67:0]  a[3];
        logic signed [67:0]  b[3];
        logic signed [67:0]  n[3];
        logic [255:0]        mag[3];
        logic [255:0]        sumsq;
        longint              q;
        for (int i = 0; i < 3; i++) begin
            r.lo[i] = t.v[0][i];
            r.hi[i] = t.v[0][i];
            for (int k = 1; k < 3; k++) begin
                if (t.v[k][i] < r.lo[i]) r.lo[i] = t.v[k][i];
                if (t.v[k][i] > r.hi[i]) r.hi[i] = t.v[k][i];
            end
            e1[i] = longint'(t.v[1][i]) - longint'(t.v[0][i]);
            e2[i] = longint'(t.v[2][i]) - longint'(t.v[0][i]);
            a[i]  = e1[i];
            b[i]  = e2[i];
        end
        // Cross product of the edge vectors e1 and e2, exact at 68 bits.
        n[0] = a[1] * b[2] - a[2] * b[1];
        n[1] = a[2] * b[0] - a[0] * b[2];
        n[2] = a[0] * b[1] - a[1] * b[0];
        sumsq = '0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = (n[i] < 0) ? 256'(-n[i]) : 256'(n[i]);
            sumsq  = sumsq + mag[i] * mag[i];
        end
        r.deg = (sumsq == '0);
        for (int i = 0; i < 3; i++) begin
            if (r.deg) begin
                r.nrm[i] = 0;
            end else begin
                q        = unit_component(mag[i], sumsq);
                r.nrm[i] = (n[i] < 0) ? -int'(q) : int'(q);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generators.
    // ------------------------------------------------------------------
    function automatic t_tri make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                      int cx, int cy, int cz);
        t_tri t;
        t.v[0] = '{ax, ay, az};
        t.v[1] = '{bx, by, bz};
        t.v[2] = '{cx, cy, cz};
        return t;
    endfunction

    // Random coordinate of a randomly chosen magnitude, so that both huge and
    // tiny triangles, and near-overflow edges, turn up often.
    function automatic int rand_coord();
        int sh;
        case ($urandom_range(0, 5))
            0:       return int'($urandom);
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return int'($urandom_range(0, 8)) - 4;
            default: begin
                sh = $urandom_range(1, 31);
                return int'($urandom) >>> sh;
            end
        endcase
    endfunction

    function automatic t_tri rand_tri();
        t_tri t;
        int   k;
        for (int v = 0; v < 3; v++) begin
            for (int i = 0; i < 3; i++) begin
                t.v[v][i] = rand_coord();
            end
        end
        case ($urandom_range(0, 9))
            // Collinear: the third vertex lies on the line of the first edge.
            0: begin
                k = int'($urandom_range(0, 6)) - 3;
                for (int i = 0; i < 3; i++) begin
                    t.v[0][i] = int'($urandom) >>> 12;
                    t.v[1][i] = t.v[0][i] + (int'($urandom) >>> 16);
                    t.v[2][i] = t.v[0][i] + k * (t.v[1][i] - t.v[0][i]);
                end
            end
            // Two coincident vertices.
            1: t.v[$urandom_range(1, 2)] = t.v[0];
            // An axis-aligned triangle: only the z raw normal component can be nonzero.
            2: begin
                for (int v = 0; v < 3; v++) t.v[v][2] = t.v[0][2];
            end
            default: ;
        endcase
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Sender. Each triangle is offered after a random gap; stretches of
    // back-to-back traffic alternate with idle-heavy stretches.
    // ------------------------------------------------------------------
    task automatic offer_triangle(t_tri t, t_bounds want, int gap);
        if (gap > 0) begin
            tri_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tri_ch.v0_x  <= t.v[0][0];
        tri_ch.v0_y  <= t.v[0][1];
        tri_ch.v0_z  <= t.v[0][2];
        tri_ch.v1_x  <= t.v[1][0];
        tri_ch.v1_y  <= t.v[1][1];
        tri_ch.v1_z  <= t.v[1][2];
        tri_ch.v2_x  <= t.v[2][0];
        tri_ch.v2_y  <= t.v[2][1];
        tri_ch.v2_z  <= t.v[2][2];
        tri_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!tri_ch.ready);
        // The transfer happened at this edge: the result is now owed.
        pending_results.insert(pending_results.size(), want);
        n_sent++;
    endtask

    function automatic int draw_gap(int idx);
        // Every fourth block of 64 items runs with no gaps at all.
        if (((idx >> 6) & 3) == 2) return 0;
        return $urandom_range(0, 11);
    endfunction

    t_row directed[$];

    task automatic build_directed();
        t_row    r;
        t_bounds z;
        int      mx;
        int      mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        // All vertices at the origin: a point, so degenerate with a zero box.
        z.lo = '{0, 0, 0}; z.hi = '{0, 0, 0}; z.nrm = '{0, 0, 0}; z.deg = 1'b1;
        r.shape = make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0); r.typed = 1; r.want = z;
        directed.insert(directed.size(), r);
        // Unit right triangle in the xy plane: normal is +z exactly.
        r.shape  = make_tri(0, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16, 0);
        r.want.lo = '{0, 0, 0}; r.want.hi = '{ONE_Q16, ONE_Q16, 0};
        r.want.nrm = '{0, 0, UNIT_ONE}; r.want.deg = 1'b0;
        directed.insert(directed.size(), r);
        // The same triangle wound the other way: normal is -z.
        r.shape = make_tri(0, 0, 0, 0, ONE_Q16, 0, ONE_Q16, 0, 0);
        r.want.nrm = '{0, 0, -UNIT_ONE};
        directed.insert(directed.size(), r);
        // Triangles in the yz and zx planes give +x and +y.
        r.shape = make_tri(0, 0, 0, 0, ONE_Q16, 0, 0, 0, ONE_Q16);
        r.want.hi = '{0, ONE_Q16, ONE_Q16}; r.want.nrm = '{UNIT_ONE, 0, 0};
        directed.insert(directed.size(), r);
        r.shape = make_tri(0, 0, 0, 0, 0, ONE_Q16, ONE_Q16, 0, 0);
        r.want.hi = '{ONE_Q16, 0, ONE_Q16}; r.want.nrm = '{0, UNIT_ONE, 0};
        directed.insert(directed.size(), r);
        // All vertices at the largest and at the smallest coordinate: degenerate.
        r.shape = make_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx);
        r.want.lo = '{mx, mx, mx}; r.want.hi = '{mx, mx, mx};
        r.want.nrm = '{0, 0, 0}; r.want.deg = 1'b1;
        directed.insert(directed.size(), r);
        r.shape = make_tri(mn, mn, mn, mn, mn, mn, mn, mn, mn);
        r.want.lo = '{mn, mn, mn}; r.want.hi = '{mn, mn, mn};
        directed.insert(directed.size(), r);
        // Collinear along the full diagonal of the coordinate range.
        r.shape = make_tri(mn, mn, mn, mx, mx, mx, 0, 0, 0);
        r.want.lo = '{mn, mn, mn}; r.want.hi = '{mx, mx, mx};
        r.want.nrm = '{0, 0, 0}; r.want.deg = 1'b1;
        directed.insert(directed.size(), r);
        // The rest go to the predictor: the widest edges, mixed extremes,
        // a one-LSB triangle, and a tie-prone normal.
        r.typed = 0;
        r.shape = make_tri(mn, mn, 0, mx, mn, 0, mn, mx, 0);
        directed.insert(directed.size(), r);
        r.shape = make_tri(mn, mn, mn, mx, mn, mx, mn, mx, mx);
        directed.insert(directed.size(), r);
        r.shape = make_tri(mx, mn, mx, mn, mx, mn, mx, mx, mn);
        directed.insert(directed.size(), r);
        r.shape = make_tri(0, 0, 0, 1, 0, 0, 0, 1, 1);
        directed.insert(directed.size(), r);
        r.shape = make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1);
        directed.insert(directed.size(), r);
        r.shape = make_tri(-1, -1, -1, 1, 2, 3, 3, 1, 2);
        directed.insert(directed.size(), r);
        r.shape = make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1);
        directed.insert(directed.size(), r);
        r.shape = make_tri(mn, 0, mx, 0, mx, mn, mx, mn, 0);
        directed.insert(directed.size(), r);
        r.shape = make_tri(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0,
                           32'h3333_3333, 32'hCCCC_CCCC, 32'h00FF_00FF);
        directed.insert(directed.size(), r);
    endtask

    initial begin
        t_tri    t;
        t_bounds p;
        tri_ch.valid <= 1'b0;
        tri_ch.v0_x <= '0; tri_ch.v0_y <= '0; tri_ch.v0_z <= '0;
        tri_ch.v1_x <= '0; tri_ch.v1_y <= '0; tri_ch.v1_z <= '0;
        tri_ch.v2_x <= '0; tri_ch.v2_y <= '0; tri_ch.v2_z <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        foreach (directed[i]) begin
            p = predict_bounds(directed[i].shape);
            offer_triangle(directed[i].shape, directed[i].typed ? directed[i].want : p,
                           $urandom_range(0, 3));
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            // Once, drain the block completely before going on.
            if (i == N_RANDOM / 3) begin
                tri_ch.valid <= 1'b0;
                @(posedge i_clk);
                while (pending_results.size() != 0) @(posedge i_clk);
            end
            t = rand_tri();
            offer_triangle(t, predict_bounds(t), draw_gap(i));
        end
        tri_ch.valid <= 1'b0;
        sending_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Receiver. Ready drops for a random number of cycles per result; once,
    // early in the random part, it stays low long enough to back the block up.
    // ------------------------------------------------------------------
    initial begin
        int stall;
        res_ch.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!hold_done && n_sent > 200) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                stall = (((n_sent >> 6) & 3) == 1) ? 0 : $urandom_range(0, 11);
                if (stall > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    // ------------------------------------------------------------------
    // Checker: every transfer on the result channel is compared with the
    // oldest prediction.
    // ------------------------------------------------------------------
    task automatic report(string what, int want, int got);
        n_mismatch++;
        if (n_mismatch <= 10)
            $display("[%0t] mismatch on %s: expected %0d (0x%08h), got %0d (0x%08h)",
                     $realtime, what, want, want, got, got);
    endtask

    always @(posedge i_clk) begin
        t_bounds w;
        int      got_lo[3];
        int      got_hi[3];
        int      got_n[3];
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_lo = '{res_ch.box_min_x, res_ch.box_min_y, res_ch.box_min_z};
            got_hi = '{res_ch.box_max_x, res_ch.box_max_y, res_ch.box_max_z};
            got_n  = '{res_ch.normal_x, res_ch.normal_y, res_ch.normal_z};
            if (pending_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("[%0t] result transfer with nothing outstanding", $realtime);
            end else begin
                w = pending_results.pop_front();
                n_checked++;
                if (w.deg) n_degenerate++;
                for (int i = 0; i < 3; i++) begin
                    if (got_lo[i] != w.lo[i])  report($sformatf("box_min[%0d]", i),
                                                      w.lo[i], got_lo[i]);
                    if (got_hi[i] != w.hi[i])  report($sformatf("box_max[%0d]", i),
                                                      w.hi[i], got_hi[i]);
                    if (got_n[i] != w.nrm[i])  report($sformatf("normal[%0d]", i),
                                                      w.nrm[i], got_n[i]);
                end
                if (res_ch.degenerate !== w.deg)
                    report("degenerate", int'(w.deg), int'(res_ch.degenerate));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transfer on either channel is a hang.
    // ------------------------------------------------------------------
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((tri_ch.valid && tri_ch.ready) || (res_ch.valid && res_ch.ready))
                idle = 0;
            else
                idle++;
            if (idle >= MAX_IDLE) begin
                $display("timeout: %0d cycles with no transfer, %0d results outstanding",
                         idle, pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // End of run: all triangles in, all results out, then a short quiet period
    // to catch any stray result.
    initial begin
        wait (sending_done);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("%0d triangles sent, %0d results checked (%0d degenerate), %0d mismatches",
                 n_sent, n_checked, n_degenerate, n_mismatch);
        if (n_mismatch == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
